// ----- hw/rtl/srfp_pkg.sv -----
// Package for the servo reply frame parser: states, status codes and control structs.
package srfp_pkg;

    localparam logic [7:0] SYNC_BYTE = 8'hFF;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_CHECKSUM = 2'd1;
    localparam logic [1:0] STATUS_LENGTH   = 2'd2;

    localparam logic [7:0] MIN_LENGTH = 8'd2;

    typedef enum logic [3:0] {
        ST_SYNC1,
        ST_SYNC2,
        ST_ID,
        ST_LEN,
        ST_ERR,
        ST_PARAM,
        ST_CSUM,
        ST_SEND,
        ST_READ,
        ST_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_id;
        logic load_len;
        logic load_err;
        logic load_param;
        logic check;
        logic rd_en;
        logic advance;
    } cmd_t;

    // Flags from the datapath back to the controller.
    typedef struct packed {
        logic byte_sync;
        logic len_short;
        logic len_two;
        logic params_done;
        logic csum_ok;
        logic cnt_zero;
        logic emit_last;
    } flags_t;

endpackage

// ----- hw/rtl/srfp_byte_if.sv -----
// Interface for the received byte channel.
interface srfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// ----- hw/rtl/srfp_result_if.sv -----
// Interface for the parsed result channel.
interface srfp_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] servo_id;
    logic [7:0] servo_error;
    logic [4:0] param_count;
    logic [3:0] param_index;
    logic [7:0] param_value;
    logic       last;

    modport source (output valid, output status, output servo_id, output servo_error,
                    output param_count, output param_index, output param_value,
                    output last, input ready);
    modport sink (input valid, input status, input servo_id, input servo_error,
                  input param_count, input param_index, input param_value,
                  input last, output ready);
endinterface

// ----- hw/rtl/srfp_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module srfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- hw/rtl/srfp_ctrl.sv -----
// Controller state machine: frame sequencing and result emission.
module srfp_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  srfp_pkg::flags_t      flags,
    output srfp_pkg::cmd_t        cmd
);

    srfp_pkg::state_t state_reg;
    srfp_pkg::state_t state_next;
    logic             accept;

    assign accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= srfp_pkg::ST_SYNC1;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            srfp_pkg::ST_SYNC1:
            begin
                if (accept && flags.byte_sync)
                begin
                    state_next = srfp_pkg::ST_SYNC2;
                end
            end
            srfp_pkg::ST_SYNC2:
            begin
                if (accept)
                begin
                    state_next = flags.byte_sync ? srfp_pkg::ST_ID : srfp_pkg::ST_SYNC1;
                end
            end
            srfp_pkg::ST_ID:
            begin
                if (accept)
                begin
                    state_next = srfp_pkg::ST_LEN;
                end
            end
            srfp_pkg::ST_LEN:
            begin
                if (accept)
                begin
                    state_next = flags.len_short ? srfp_pkg::ST_SEND : srfp_pkg::ST_ERR;
                end
            end
            srfp_pkg::ST_ERR:
            begin
                if (accept)
                begin
                    state_next = flags.len_two ? srfp_pkg::ST_CSUM : srfp_pkg::ST_PARAM;
                end
            end
            srfp_pkg::ST_PARAM:
            begin
                if (accept && flags.params_done)
                begin
                    state_next = srfp_pkg::ST_CSUM;
                end
            end
            srfp_pkg::ST_CSUM:
            begin
                if (accept)
                begin
                    if (!flags.csum_ok || flags.cnt_zero)
                    begin
                        state_next = srfp_pkg::ST_SEND;
                    end
                    else
                    begin
                        state_next = srfp_pkg::ST_READ;
                    end
                end
            end
            srfp_pkg::ST_SEND:
            begin
                if (out_ready)
                begin
                    state_next = srfp_pkg::ST_SYNC1;
                end
            end
            srfp_pkg::ST_READ:
            begin
                state_next = srfp_pkg::ST_EMIT;
            end
            srfp_pkg::ST_EMIT:
            begin
                if (out_ready)
                begin
                    state_next = flags.emit_last ? srfp_pkg::ST_SYNC1 : srfp_pkg::ST_READ;
                end
            end
            default:
            begin
                state_next = srfp_pkg::ST_SYNC1;
            end
        endcase
    end

    always_comb
    begin
        in_ready       = 1'b0;
        out_valid      = 1'b0;
        cmd            = '0;
        case (state_reg)
            srfp_pkg::ST_SYNC1, srfp_pkg::ST_SYNC2:
            begin
                in_ready = 1'b1;
            end
            srfp_pkg::ST_ID:
            begin
                in_ready    = 1'b1;
                cmd.load_id = accept;
            end
            srfp_pkg::ST_LEN:
            begin
                in_ready     = 1'b1;
                cmd.load_len = accept;
            end
            srfp_pkg::ST_ERR:
            begin
                in_ready     = 1'b1;
                cmd.load_err = accept;
            end
            srfp_pkg::ST_PARAM:
            begin
                in_ready       = 1'b1;
                cmd.load_param = accept;
            end
            srfp_pkg::ST_CSUM:
            begin
                in_ready  = 1'b1;
                cmd.check = accept;
            end
            srfp_pkg::ST_SEND:
            begin
                out_valid = 1'b1;
            end
            srfp_pkg::ST_READ:
            begin
                cmd.rd_en = 1'b1;
            end
            srfp_pkg::ST_EMIT:
            begin
                out_valid   = 1'b1;
                cmd.advance = out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ----- hw/rtl/srfp_dp.sv -----
// Datapath: frame header registers, checksum, parameter store and result fields.
module srfp_dp #(
    parameter int MAX_PARAMS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [7:0]       rx_byte,
    input  srfp_pkg::cmd_t   cmd,
    output srfp_pkg::flags_t flags,
    output logic [1:0]       status,
    output logic [7:0]       servo_id,
    output logic [7:0]       servo_error,
    output logic [4:0]       param_count,
    output logic [3:0]       param_index,
    output logic [7:0]       param_value,
    output logic             last
);

    localparam int AW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
    localparam int CW = $clog2(MAX_PARAMS + 1);
    localparam logic [7:0] MAX_P8 = 8'(MAX_PARAMS);

    logic [7:0]    id_reg;
    logic [7:0]    length_reg;
    logic [7:0]    error_reg;
    logic [7:0]    sum_reg;
    logic [7:0]    seen_reg;
    logic [1:0]    status_reg;
    logic          emit_param_reg;
    logic [CW-1:0] index_reg;

    logic [7:0]    sum_next;
    logic [7:0]    avail;
    logic [CW-1:0] kept;
    logic [8:0]    seen_inc;
    logic [8:0]    params_total;
    logic          store_wr;
    logic [7:0]    ram_rd_data;

    assign sum_next     = sum_reg + rx_byte;
    assign avail        = (length_reg >= srfp_pkg::MIN_LENGTH) ?
                          (length_reg - srfp_pkg::MIN_LENGTH) : 8'd0;
    assign kept         = (avail > MAX_P8) ? CW'(MAX_PARAMS) : CW'(avail);
    assign seen_inc     = {1'b0, seen_reg} + 9'd1;
    assign params_total = {1'b0, length_reg} - {1'b0, srfp_pkg::MIN_LENGTH};
    // Parameters past the store depth still enter the checksum but are dropped.
    assign store_wr     = cmd.load_param && (seen_reg < MAX_P8);

    always_comb
    begin
        flags.byte_sync   = (rx_byte == srfp_pkg::SYNC_BYTE);
        flags.len_short   = (rx_byte < srfp_pkg::MIN_LENGTH);
        flags.len_two     = (length_reg == srfp_pkg::MIN_LENGTH);
        flags.params_done = (seen_inc >= params_total);
        flags.csum_ok     = (~sum_reg == rx_byte);
        flags.cnt_zero    = (kept == '0);
        flags.emit_last   = !emit_param_reg || ((index_reg + CW'(1)) == kept);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_reg         <= '0;
            length_reg     <= '0;
            error_reg      <= '0;
            sum_reg        <= '0;
            seen_reg       <= '0;
            status_reg     <= srfp_pkg::STATUS_OK;
            emit_param_reg <= 1'b0;
            index_reg      <= '0;
        end
        else
        begin
            if (cmd.load_id)
            begin
                id_reg <= rx_byte;
            end
            if (cmd.load_len)
            begin
                length_reg     <= rx_byte;
                sum_reg        <= id_reg + rx_byte;
                seen_reg       <= '0;
                index_reg      <= '0;
                emit_param_reg <= 1'b0;
                if (rx_byte < srfp_pkg::MIN_LENGTH)
                begin
                    error_reg  <= '0;
                    status_reg <= srfp_pkg::STATUS_LENGTH;
                end
            end
            if (cmd.load_err)
            begin
                error_reg <= rx_byte;
                sum_reg   <= sum_next;
            end
            if (cmd.load_param)
            begin
                sum_reg  <= sum_next;
                seen_reg <= seen_inc[7:0];
            end
            if (cmd.check)
            begin
                index_reg <= '0;
                if (~sum_reg == rx_byte)
                begin
                    status_reg     <= srfp_pkg::STATUS_OK;
                    emit_param_reg <= (kept != '0);
                end
                else
                begin
                    status_reg     <= srfp_pkg::STATUS_CHECKSUM;
                    emit_param_reg <= 1'b0;
                end
            end
            if (cmd.advance)
            begin
                index_reg <= index_reg + CW'(1);
            end
        end
    end

    srfp_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PARAMS)
    ) u_store (
        .clk     (clk),
        .wr_en   (store_wr),
        .wr_addr (seen_reg[AW-1:0]),
        .wr_data (rx_byte),
        .rd_en   (cmd.rd_en),
        .rd_addr (index_reg[AW-1:0]),
        .rd_data (ram_rd_data)
    );

    assign status      = status_reg;
    assign servo_id    = id_reg;
    assign servo_error = error_reg;
    assign param_count = 5'(kept);
    assign param_index = 4'(index_reg);
    assign param_value = emit_param_reg ? ram_rd_data : 8'd0;
    assign last        = flags.emit_last;

endmodule

// ----- hw/rtl/servo_reply_frame_parser.sv -----
// Top level of the servo reply frame parser.
//
//  Channel  Direction  Payload
//  rx       in         rx_byte
//  res      out        status, servo_id, servo_error, param_count, param_index,
//                      param_value, last
//
// Every received byte is accepted while the parser is in a header,
// parameter or checksum phase. Results hold the input off: a single result is
// presented until res.ready, and each parameter result is a parameter store
// read followed by a presentation that is held until res.ready.
// A stall on res freezes the parser with the result held steady.
// Reset is asynchronous and returns the parser to hunting for the first sync byte.
module servo_reply_frame_parser #(
    parameter int MAX_PARAMS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    srfp_byte_if.sink            rx,
    srfp_result_if.source        res
);

    srfp_pkg::cmd_t   cmd;
    srfp_pkg::flags_t flags;

    srfp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rx.valid),
        .in_ready  (rx.ready),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .flags     (flags),
        .cmd       (cmd)
    );

    srfp_dp #(
        .MAX_PARAMS (MAX_PARAMS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx_byte     (rx.rx_byte),
        .cmd         (cmd),
        .flags       (flags),
        .status      (res.status),
        .servo_id    (res.servo_id),
        .servo_error (res.servo_error),
        .param_count (res.param_count),
        .param_index (res.param_index),
        .param_value (res.param_value),
        .last        (res.last)
    );

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the servo reply frame parser.
module tb_top;

    localparam int MAX_PARAMS  = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 40;

    typedef enum logic [1:0] {
        FILL_RANDOM,
        FILL_ZERO,
        FILL_ONES,
        FILL_RAMP
    } fill_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] servo_id;
        logic [7:0] servo_error;
        logic [4:0] param_count;
        logic [3:0] param_index;
        logic [7:0] param_value;
        logic       last;
    } reply_t;

    logic clk;
    logic rst_n;

    srfp_byte_if   byte_ch ();
    srfp_result_if reply_ch ();

    servo_reply_frame_parser #(
        .MAX_PARAMS(MAX_PARAMS)
    ) u_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .rx   (byte_ch),
        .res  (reply_ch)
    );

    // Parser state as tracked by the testbench.
    srfp_pkg::state_t parse_phase = srfp_pkg::ST_SYNC1;
    logic [7:0] cur_id      = 8'd0;
    logic [7:0] cur_len     = 8'd0;
    logic [7:0] cur_err     = 8'd0;
    logic [7:0] cur_sum     = 8'd0;
    logic [7:0] params_seen = 8'd0;
    logic [7:0] param_bytes [MAX_PARAMS];

    reply_t pending_replies[$];
    int     replies_queued = 0;
    int     frame_bytes    = 0;
    int     error_count    = 0;
    int     cycle_count    = 0;
    bit     gaps_on        = 1'b1;
    bit     stalls_on      = 1'b1;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic void queue_reply(input logic [1:0] status, input int count,
                                        input int index, input logic [7:0] value,
                                        input logic last);
        reply_t r;
        r.status      = status;
        r.servo_id    = cur_id;
        r.servo_error = cur_err;
        r.param_count = count[4:0];
        r.param_index = index[3:0];
        r.param_value = value;
        r.last        = last;
        pending_replies.push_back(r);
        replies_queued++;
    endfunction

    function automatic void parse_byte(input logic [7:0] b);
        int kept;
        case (parse_phase)
            srfp_pkg::ST_SYNC1:
            begin
                if (b == srfp_pkg::SYNC_BYTE)
                    parse_phase = srfp_pkg::ST_SYNC2;
            end
            srfp_pkg::ST_SYNC2:
                parse_phase = (b == srfp_pkg::SYNC_BYTE) ? srfp_pkg::ST_ID :
                                                            srfp_pkg::ST_SYNC1;
            srfp_pkg::ST_ID:
            begin
                cur_id      = b;
                parse_phase = srfp_pkg::ST_LEN;
            end
            srfp_pkg::ST_LEN:
            begin
                cur_len = b;
                if (b < srfp_pkg::MIN_LENGTH)
                begin
                    cur_err = 8'd0;
                    queue_reply(srfp_pkg::STATUS_LENGTH, 0, 0, 8'd0, 1'b1);
                    parse_phase = srfp_pkg::ST_SYNC1;
                end
                else
                begin
                    cur_sum     = cur_id + b;
                    params_seen = 8'd0;
                    parse_phase = srfp_pkg::ST_ERR;
                end
            end
            srfp_pkg::ST_ERR:
            begin
                cur_err     = b;
                cur_sum     = cur_sum + b;
                parse_phase = (cur_len == srfp_pkg::MIN_LENGTH) ? srfp_pkg::ST_CSUM :
                                                                   srfp_pkg::ST_PARAM;
            end
            srfp_pkg::ST_PARAM:
            begin
                // Bytes past the store size still count toward the checksum.
                if (params_seen < MAX_PARAMS)
                    param_bytes[params_seen] = b;
                cur_sum     = cur_sum + b;
                params_seen = params_seen + 8'd1;
                if (params_seen >= cur_len - srfp_pkg::MIN_LENGTH)
                    parse_phase = srfp_pkg::ST_CSUM;
            end
            srfp_pkg::ST_CSUM:
            begin
                parse_phase = srfp_pkg::ST_SYNC1;
                kept = int'(cur_len) - 2;
                if (kept > MAX_PARAMS)
                    kept = MAX_PARAMS;
                if (~cur_sum != b)
                    queue_reply(srfp_pkg::STATUS_CHECKSUM, kept, 0, 8'd0, 1'b1);
                else if (kept == 0)
                    queue_reply(srfp_pkg::STATUS_OK, 0, 0, 8'd0, 1'b1);
                else
                    for (int k = 0; k < kept; k++)
                        queue_reply(srfp_pkg::STATUS_OK, kept, k, param_bytes[k],
                                    k == kept - 1);
            end
            default:
                parse_phase = srfp_pkg::ST_SYNC1;
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b);
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        byte_ch.valid   <= 1'b1;
        byte_ch.rx_byte <= b;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        parse_byte(b);
    endtask

    task automatic send_frame(input logic [7:0] id, input logic [7:0] len,
                              input logic [7:0] err, input fill_t fill,
                              input bit corrupt);
        logic [7:0] sum;
        logic [7:0] pb;
        send_byte(srfp_pkg::SYNC_BYTE);
        send_byte(srfp_pkg::SYNC_BYTE);
        send_byte(id);
        send_byte(len);
        if (len < srfp_pkg::MIN_LENGTH)
        begin
            frame_bytes += 4;
            return;
        end
        frame_bytes += int'(len) + 4;
        sum = id + len + err;
        send_byte(err);
        for (int k = 0; k < int'(len) - 2; k++)
        begin
            case (fill)
                FILL_ZERO: pb = 8'h00;
                FILL_ONES: pb = 8'hFF;
                FILL_RAMP: pb = k[7:0];
                default:   pb = 8'($urandom_range(0, 255));
            endcase
            sum = sum + pb;
            send_byte(pb);
        end
        sum = ~sum;
        if (corrupt)
            sum = sum ^ 8'($urandom_range(1, 255));
        send_byte(sum);
    endtask

    // Mostly well-formed frames with random content, some noise and bad frames.
    task automatic send_random_frame();
        int         pick;
        logic [7:0] len;
        fill_t      fill;
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 254)));
        if ($urandom_range(0, 9) == 0)
        begin
            send_byte(srfp_pkg::SYNC_BYTE);
            send_byte(8'($urandom_range(0, 254)));
        end
        pick = $urandom_range(0, 99);
        if (pick < 8)
            len = 8'($urandom_range(0, 1));
        else if (pick < 78)
            len = 8'($urandom_range(2, 10));
        else if (pick < 97)
            len = 8'($urandom_range(11, 20));
        else
            len = 8'($urandom_range(21, 40));
        pick = $urandom_range(0, 19);
        fill = (pick == 0) ? FILL_ZERO : (pick == 1) ? FILL_ONES : FILL_RANDOM;
        send_frame(8'($urandom_range(0, 255)), len, 8'($urandom_range(0, 255)), fill,
                   $urandom_range(0, 99) < 15);
    endtask

    task automatic test_directed();
        send_frame(8'h01, 8'd2, 8'h00, FILL_ZERO, 1'b0);
        send_frame(8'hFF, 8'd3, 8'hFF, FILL_ONES, 1'b0);
        send_frame(8'h00, 8'd18, 8'h80, FILL_RAMP, 1'b0);
        send_frame(8'h7F, 8'd21, 8'h01, FILL_ONES, 1'b0);
        send_frame(8'h12, 8'd6, 8'h20, FILL_RANDOM, 1'b1);
        send_frame(8'h33, 8'd40, 8'h44, FILL_RANDOM, 1'b1);
        send_frame(8'h34, 8'd0, 8'h00, FILL_ZERO, 1'b0);
        send_frame(8'h56, 8'd1, 8'h00, FILL_ZERO, 1'b0);
        // A lone sync byte followed by anything else drops back to the hunt.
        send_byte(srfp_pkg::SYNC_BYTE);
        send_byte(8'h00);
        send_frame(8'h5A, 8'd4, 8'hA5, FILL_RAMP, 1'b0);
        send_byte(8'h00);
        send_byte(srfp_pkg::SYNC_BYTE);
        send_byte(8'hFE);
        send_frame(8'hAA, 8'd64, 8'h55, FILL_RANDOM, 1'b0);
    endtask

    task automatic test_random_traffic();
        int bytes_start;
        int replies_start;
        bytes_start   = frame_bytes;
        replies_start = replies_queued;
        while (frame_bytes - bytes_start < 80 || replies_queued - replies_start < 24)
        begin
            gaps_on   = $urandom_range(0, 3) != 0;
            stalls_on = $urandom_range(0, 3) != 0;
            send_random_frame();
        end
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
    endtask

    task automatic test_drain_pause();
        repeat (3) send_random_frame();
        byte_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (3) send_random_frame();
    endtask

    task automatic test_back_to_back();
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        repeat (5) send_random_frame();
        send_frame(8'h10, 8'd18, 8'h00, FILL_RANDOM, 1'b0);
    endtask

    initial
    begin
        reply_ch.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (stalls_on && $urandom_range(0, 4) == 0)
            begin
                reply_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            else
            begin
                reply_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    function automatic string reply_text(input reply_t r);
        return $sformatf("status=%0d id=%02h err=%02h count=%0d index=%0d value=%02h last=%0b",
                         r.status, r.servo_id, r.servo_error, r.param_count,
                         r.param_index, r.param_value, r.last);
    endfunction

    function automatic void report_mismatch(input string what, input reply_t want,
                                            input reply_t got);
        error_count++;
        if (error_count <= 10)
            $display("%s: expected %s / actual %s", what, reply_text(want), reply_text(got));
    endfunction

    always @(posedge clk)
    begin
        reply_t got;
        reply_t want;
        cycle_count++;
        if (rst_n && reply_ch.valid && reply_ch.ready)
        begin
            got.status      = reply_ch.status;
            got.servo_id    = reply_ch.servo_id;
            got.servo_error = reply_ch.servo_error;
            got.param_count = reply_ch.param_count;
            got.param_index = reply_ch.param_index;
            got.param_value = reply_ch.param_value;
            got.last        = reply_ch.last;
            if (pending_replies.size() == 0)
            begin
                report_mismatch("Reply transaction with none pending", '0, got);
            end
            else
            begin
                want = pending_replies.pop_front();
                if (got.status !== want.status || got.servo_id !== want.servo_id ||
                    got.servo_error !== want.servo_error ||
                    got.param_count !== want.param_count ||
                    got.param_index !== want.param_index ||
                    got.param_value !== want.param_value || got.last !== want.last)
                    report_mismatch("Reply mismatch", want, got);
            end
        end
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        byte_ch.valid   <= 1'b0;
        byte_ch.rx_byte <= 8'h00;
        rst_n           <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_traffic();
        test_drain_pause();
        test_back_to_back();

        byte_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (error_count == 0 && pending_replies.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/srfp_pkg.sv
hw/rtl/srfp_byte_if.sv
hw/rtl/srfp_result_if.sv
hw/rtl/srfp_ram.sv
hw/rtl/srfp_ctrl.sv
hw/rtl/srfp_dp.sv
hw/rtl/servo_reply_frame_parser.sv
tb/sv/tb_top.sv
